// ===== rtl/p2ba_pkg.sv =====
// Package for the power-of-two block allocator: sizing constants, payload
// structs, status codes, controller states and the controller/datapath link.
// No dependencies.
`default_nettype none

package p2ba_pkg;

  localparam int FRAME_COUNT = 16;
  localparam int FRAME_BYTES = 16;
  localparam int MAX_ORDER   = 4;

  localparam int FW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int ORD_W  = $clog2(MAX_ORDER + 1) > 0 ? $clog2(MAX_ORDER + 1) : 1;
  localparam int RUN_W  = ((FW > MAX_ORDER) ? FW : MAX_ORDER) + 1;
  localparam int BYTE_W = $clog2(FRAME_BYTES) + 1;
  localparam int AW     = (FW + 1 + BYTE_W > 8) ? FW + 1 + BYTE_W : 8;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [7:0]  owner_id;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] base_address;
    logic [7:0] last_address;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC_SCAN,
    S_ALLOC_TAG,
    S_FREE_SCAN,
    S_POST
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    step;
    logic    tag;
    logic    post;
    status_t post_status;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic op_free;
    logic owner_zero;
    logic run_too_big;
    logic hit;
    logic scan_last;
    logic found_any;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/p2ba_dpath.sv =====
// Datapath of the allocator: frame owner tags, request latch, frame scan
// and result register. Uses p2ba_pkg; driven by p2ba_ctrl commands.
`default_nettype none

module p2ba_dpath
  import p2ba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output out_t      out_data
);

  logic [7:0]       tag_r [FRAME_COUNT];
  logic             op_r;
  logic [15:0]      size_r;
  logic [7:0]       owner_r;
  logic [ORD_W-1:0] order_r;
  logic             fits_r;
  logic [FW-1:0]    idx_r;
  logic             run_ok_r;
  logic [FW-1:0]    start_r;
  logic             found_r;
  logic [FW-1:0]    lo_r;
  logic [FW-1:0]    hi_r;
  out_t             out_r;

  logic [ORD_W-1:0] ord_c;
  logic             fits_c;
  logic [RUN_W-1:0] run;
  logic [FW-1:0]    mask;
  logic [FW-1:0]    pos;
  logic [7:0]       cur_tag;
  logic             ok_now;
  logic             match_now;
  logic [7:0]       base_c;
  logic [7:0]       last_c;

  // byte address of a frame boundary, low 8 bits
  function automatic logic [7:0] frame_addr(input logic [FW:0] f);
    logic [AW-1:0] p;
    p = AW'(f) * AW'(FRAME_BYTES);
    return p[7:0];
  endfunction

  // smallest order whose block holds the requested size
  always_comb begin
    ord_c  = '0;
    fits_c = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (32'(in_data.request_size) <= (32'(FRAME_BYTES) << k)) begin
        ord_c  = ORD_W'(k);
        fits_c = 1'b1;
      end
    end
  end

  assign run       = RUN_W'(1) << order_r;
  assign mask      = FW'(run - RUN_W'(1));
  assign pos       = idx_r & mask;
  assign cur_tag   = tag_r[idx_r];
  assign ok_now    = ((pos == '0) || run_ok_r) && (cur_tag == 8'd0);
  assign match_now = (cur_tag == owner_r);

  assign sts.req_bad     = (op_r == OP_ALLOC) &&
                           ((size_r == 16'd0) || (owner_r == 8'd0) || !fits_r);
  assign sts.op_free     = (op_r == OP_FREE);
  assign sts.owner_zero  = (owner_r == 8'd0);
  assign sts.run_too_big = (run > RUN_W'(FRAME_COUNT));
  assign sts.hit         = ok_now && (pos == mask);
  assign sts.scan_last   = (idx_r == FW'(FRAME_COUNT - 1));
  assign sts.found_any   = found_r || match_now;

  always_comb begin
    base_c = 8'd0;
    last_c = 8'd0;
    case (cmd.post_status)
      ST_ALLOCATED: begin
        base_c = frame_addr({1'b0, start_r});
        last_c = frame_addr({1'b0, start_r} + (FW + 1)'(run)) - 8'd1;
      end
      ST_FREED: begin
        base_c = frame_addr({1'b0, lo_r});
        last_c = frame_addr({1'b0, hi_r} + 1'b1) - 8'd1;
      end
      default: begin
        base_c = 8'd0;
        last_c = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_COUNT; i++) tag_r[i] <= 8'd0;
    end else begin
      if (cmd.step && !op_r && sts.hit) begin
        start_r <= idx_r & ~mask;
      end
      if (cmd.step) begin
        if (op_r == OP_ALLOC) begin
          run_ok_r <= ok_now;
        end else if (match_now) begin
          tag_r[idx_r] <= 8'd0;
          if (!found_r) lo_r <= idx_r;
          hi_r    <= idx_r;
          found_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.tag) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if ((FW'(i) & ~mask) == start_r) tag_r[i] <= owner_r;
        end
      end
    end
    if (cmd.accept) begin
      op_r     <= in_data.operation;
      size_r   <= in_data.request_size;
      owner_r  <= in_data.owner_id;
      order_r  <= ord_c;
      fits_r   <= fits_c;
      idx_r    <= '0;
      run_ok_r <= 1'b0;
      found_r  <= 1'b0;
    end
    if (cmd.post) begin
      out_r.status       <= cmd.post_status;
      out_r.base_address <= base_c;
      out_r.last_address <= last_c;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/p2ba_ctrl.sv =====
// Controller of the allocator: request sequencing and output handshake.
// Uses p2ba_pkg; commands p2ba_dpath.
`default_nettype none

module p2ba_ctrl
  import p2ba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t pend_r, pend_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= ST_BAD_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    cmd             = '0;
    cmd.post_status = pend_r;
    in_stall        = 1'b1;
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op_free) begin
          if (sts.owner_zero) begin
            pend_nxt  = ST_NOT_FOUND;
            state_nxt = S_POST;
          end else begin
            state_nxt = S_FREE_SCAN;
          end
        end else if (sts.req_bad) begin
          pend_nxt  = ST_BAD_SIZE;
          state_nxt = S_POST;
        end else if (sts.run_too_big) begin
          pend_nxt  = ST_NO_SPACE;
          state_nxt = S_POST;
        end else begin
          state_nxt = S_ALLOC_SCAN;
        end
      end
      S_ALLOC_SCAN: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          state_nxt = S_ALLOC_TAG;
        end else if (sts.scan_last) begin
          pend_nxt  = ST_NO_SPACE;
          state_nxt = S_POST;
        end
      end
      S_ALLOC_TAG: begin
        cmd.tag   = 1'b1;
        pend_nxt  = ST_ALLOCATED;
        state_nxt = S_POST;
      end
      S_FREE_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          pend_nxt  = sts.found_any ? ST_FREED : ST_NOT_FOUND;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/power_of_two_block_allocator.sv =====
// Top level of the power-of-two block allocator.
// Uses p2ba_pkg, p2ba_ctrl and p2ba_dpath.
`default_nettype none

// Buddy-style allocator over FRAME_COUNT frames of FRAME_BYTES bytes, one
// owner tag per frame (tag 0 = free, all free after reset). An allocate
// request (operation 0) picks the smallest power-of-two run that holds
// request_size, takes the first naturally aligned fully free run and returns
// its byte range; zero size, oversize or owner 0 reports status 1, no room
// status 2. A free request (operation 1) clears every frame of owner_id and
// returns the range from its first to last frame, or status 4 if it holds
// nothing. Addresses are reported modulo 256 and are zero on every error.
// Sequencing: one request at a time. The frame scan visits one tag per cycle;
// a request rejected up front goes from S_CHECK straight to S_POST, a free
// or an allocate scan without a hit walks all FRAME_COUNT frames, and an
// allocate that hits passes S_ALLOC_TAG to tag its run. Posting also
// waits while the previous result is still stalled in the output register.
// in_stall is low only while the controller is idle; the result sits in an
// output register, so a new request is taken while the previous result
// still waits for its transfer.
module power_of_two_block_allocator
  import p2ba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  p2ba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  p2ba_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // error results never carry an address
  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_BAD_SIZE || out_data.status == ST_NO_SPACE ||
                  out_data.status == ST_NOT_FOUND)
    |-> (out_data.base_address == 8'd0) && (out_data.last_address == 8'd0))
    else $error("error result with nonzero address");

  // one request in flight: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in progress");

  // a new result only appears while the block is busy finishing a request
  a_post_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result posted without a request in progress");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
